[hdl/dcm_seq_pkg.sv]
// Package for the DC motor mode sequencer: key codes, mode codes, limits, result layout.
`timescale 1ns / 1ps

package dcm_seq_pkg;

    // Base ticks per 50 ms slot and slots in one pause
    localparam int TICKS_PER_SLOT = 500;
    localparam int PAUSE_SLOTS    = 20;
    localparam int PRESCALE_W     = $clog2(TICKS_PER_SLOT + 1);

    // Active-low key port codes
    localparam logic [7:0] KEY_START = 8'hFE;
    localparam logic [7:0] KEY_STOP  = 8'hFD;
    localparam logic [7:0] KEY_MODE  = 8'hFB;
    localparam logic [7:0] KEY_DIR   = 8'hF7;
    localparam logic [7:0] KEY_SPDUP = 8'hEF;
    localparam logic [7:0] KEY_SPDDN = 8'hDF;
    localparam logic [7:0] KEY_TUP   = 8'hBF;
    localparam logic [7:0] KEY_TDN   = 8'h7F;

    // Request kinds on the input tuser bit
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // PWM period in ticks and off time limits
    localparam logic [4:0] PWM_PERIOD = 5'd20;
    localparam logic [3:0] OFF_MIN    = 4'd6;
    localparam logic [3:0] OFF_MAX    = 4'd14;
    localparam logic [3:0] OFF_RESET  = 4'd10;
    localparam logic [3:0] SPEED_BIAS = 4'd5;

    // Run time kept in units of 20 slots
    localparam logic [3:0] RUN_SEC_MIN   = 4'd1;
    localparam logic [3:0] RUN_SEC_MAX   = 4'd9;
    localparam logic [3:0] RUN_SEC_RESET = 4'd5;

    typedef enum logic [1:0] {
        MODE_CONT = 2'd0,
        MODE_REV  = 2'd1,
        MODE_JOG  = 2'd2
    } mode_t;

    // Result layout, lowest bit last
    typedef struct packed {
        logic [5:0] pad;
        logic [3:0] run_seconds;
        logic [3:0] speed_level;
        logic [1:0] mode_now;
        logic       running;
        logic       ccw_led;
        logic       cw_led;
        logic       stop_led;
        logic       run_led;
        logic       direction_relay;
        logic       power_relay;
        logic       pwm_out;
    } result_t;

endpackage

[hdl/dc_motor_mode_sequencer.sv]
// Top level of the DC motor mode sequencer: key and tick decode, cycle state, result register.
// The result of an accepted request is written to the output register.
// Throughput: one request per clock while the output register is empty or drained; the next-state
// logic is a single pass of short compares and increments between the state and result registers.
// Reset: rst_n resets all sequencer state asynchronously; output register empty, motor stopped.
`timescale 1ns / 1ps

module dc_motor_mode_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_code
    input  logic        s_tuser,   // [0] op: 0 tick, 1 key event
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] pwm_out, [1] power_relay, [2] direction_relay,
                                   // [3] run_led, [4] stop_led, [5] cw_led, [6] ccw_led,
                                   // [7] running, [9:8] mode_now, [13:10] speed_level,
                                   // [17:14] run_seconds, [23:18] zero
);
    import dcm_seq_pkg::*;

    // Sequencer state
    logic                  run_reg, run_next;
    mode_t                 mode_reg, mode_next;
    logic                  dir_cnt_reg, dir_cnt_next;
    logic [3:0]            off_reg, off_next;
    logic [3:0]            run_sec_reg, run_sec_next;
    logic [1:0]            phase_reg, phase_next;
    logic [7:0]            slot_reg, slot_next;
    logic [PRESCALE_W-1:0] pre_reg, pre_next;
    logic [3:0]            pwm_cnt_reg, pwm_cnt_next;
    logic                  pin_reg, pin_next;
    logic                  power_reg, power_next;
    logic                  dirrel_reg, dirrel_next;
    logic                  led_run_reg, led_run_next;
    logic                  led_stop_reg, led_stop_next;
    logic                  led_cw_reg, led_cw_next;
    logic                  led_ccw_reg, led_ccw_next;

    // Output register
    logic                  valid_reg, valid_next;
    result_t               res_reg, res_next;

    logic                  accept;
    logic                  do_start;
    logic                  do_enter;
    logic [7:0]            run_slots;
    logic [7:0]            slot_lim;
    logic [4:0]            pwm_dur;
    logic [PRESCALE_W-1:0] pre_inc;
    logic [3:0]            pwm_inc;

    // Take a new request whenever the output register is empty or draining
    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Run time in slots is run_sec * 20, built from two shifts
    assign run_slots = {run_sec_reg, 4'b0000} + {2'b00, run_sec_reg, 2'b00};
    assign slot_lim  = phase_reg[0] ? 8'(PAUSE_SLOTS) : run_slots;
    assign pwm_dur   = (phase_reg == 2'd0) ? (PWM_PERIOD - {1'b0, off_reg}) : {1'b0, off_reg};
    assign pre_inc   = pre_reg + 1'b1;
    assign pwm_inc   = pwm_cnt_reg + 4'd1;

    always_comb
    begin
        run_next      = run_reg;
        mode_next     = mode_reg;
        dir_cnt_next  = dir_cnt_reg;
        off_next      = off_reg;
        run_sec_next  = run_sec_reg;
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        pre_next      = pre_reg;
        pwm_cnt_next  = pwm_cnt_reg;
        pin_next      = pin_reg;
        power_next    = power_reg;
        dirrel_next   = dirrel_reg;
        led_run_next  = led_run_reg;
        led_stop_next = led_stop_reg;
        led_cw_next   = led_cw_reg;
        led_ccw_next  = led_ccw_reg;
        do_start      = 1'b0;
        do_enter      = 1'b0;

        if (s_tuser == OP_KEY)
        begin
            case (s_tdata)
                KEY_START:
                begin
                    led_run_next  = 1'b1;
                    led_stop_next = 1'b0;
                    led_cw_next   = 1'b1;
                    led_ccw_next  = 1'b0;
                    do_start      = 1'b1;
                end
                KEY_STOP:
                begin
                    // Drop the run flag, power down and clear the cycle counters
                    run_next      = 1'b0;
                    phase_next    = 2'd0;
                    slot_next     = 8'd0;
                    pwm_cnt_next  = 4'd0;
                    pre_next      = '0;
                    led_run_next  = 1'b0;
                    led_stop_next = 1'b1;
                    led_cw_next   = 1'b0;
                    led_ccw_next  = 1'b0;
                    power_next    = 1'b0;
                    pin_next      = 1'b0;
                end
                KEY_MODE:
                begin
                    mode_next = (mode_reg == MODE_REV) ? MODE_JOG :
                                (mode_reg == MODE_CONT) ? MODE_REV : MODE_CONT;
                    do_start  = run_reg;
                end
                KEY_DIR:
                begin
                    dir_cnt_next = !dir_cnt_reg;
                    led_cw_next  = dir_cnt_reg;
                    led_ccw_next = !dir_cnt_reg;
                    dirrel_next  = dir_cnt_reg;
                    do_start     = run_reg;
                end
                KEY_SPDUP:
                begin
                    if (off_reg > OFF_MIN)
                    begin
                        off_next = off_reg - 4'd1;
                    end
                    do_start = run_reg;
                end
                KEY_SPDDN:
                begin
                    if (off_reg < OFF_MAX)
                    begin
                        off_next = off_reg + 4'd1;
                    end
                    do_start = run_reg;
                end
                KEY_TUP:
                begin
                    if (run_sec_reg < RUN_SEC_MAX)
                    begin
                        run_sec_next = run_sec_reg + 4'd1;
                    end
                    do_start = run_reg;
                end
                KEY_TDN:
                begin
                    if (run_sec_reg > RUN_SEC_MIN)
                    begin
                        run_sec_next = run_sec_reg - 4'd1;
                    end
                    do_start = run_reg;
                end
                default:
                begin
                    // Unknown key: hold everything
                end
            endcase
        end
        else if (run_reg)
        begin
            case (mode_reg)
                MODE_REV, MODE_JOG:
                begin
                    // Advance the slot prescaler; at slot end advance the slot or the phase
                    pre_next = pre_inc;
                    if (pre_inc >= PRESCALE_W'(TICKS_PER_SLOT))
                    begin
                        pre_next = '0;
                        if (slot_reg >= slot_lim)
                        begin
                            slot_next  = 8'd0;
                            phase_next = (mode_reg == MODE_REV) ? phase_reg + 2'd1
                                                                : {1'b0, !phase_reg[0]};
                            do_enter   = 1'b1;
                        end
                        else
                        begin
                            slot_next = slot_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    // Continuous software PWM: high for 20 - off ticks, low for off ticks
                    pwm_cnt_next = pwm_inc;
                    if ({1'b0, pwm_inc} >= pwm_dur)
                    begin
                        pwm_cnt_next = 4'd0;
                        phase_next   = {1'b0, !phase_reg[0]};
                        do_enter     = 1'b1;
                    end
                end
            endcase
        end

        // Start or restart the cycle of the (possibly new) mode
        if (do_start)
        begin
            run_next     = 1'b1;
            phase_next   = 2'd0;
            slot_next    = 8'd0;
            pwm_cnt_next = 4'd0;
            pre_next     = '0;
            if (mode_next != MODE_REV && mode_next != MODE_JOG)
            begin
                power_next = 1'b1;
            end
            do_enter = 1'b1;
        end

        // Phase entry actions
        if (do_enter)
        begin
            case (mode_next)
                MODE_REV:
                begin
                    if (phase_next == 2'd0)
                    begin
                        led_run_next = 1'b1;
                        led_cw_next  = 1'b1;
                        led_ccw_next = 1'b0;
                        pin_next     = 1'b1;
                        dirrel_next  = 1'b1;
                        power_next   = 1'b1;
                    end
                    else if (phase_next == 2'd2)
                    begin
                        led_run_next = 1'b1;
                        led_cw_next  = 1'b0;
                        led_ccw_next = 1'b1;
                        dirrel_next  = 1'b0;
                        power_next   = 1'b1;
                    end
                    else
                    begin
                        power_next   = 1'b0;
                        led_run_next = 1'b0;
                    end
                end
                MODE_JOG:
                begin
                    if (phase_next == 2'd0)
                    begin
                        led_run_next = 1'b1;
                        pin_next     = 1'b1;
                        power_next   = 1'b1;
                    end
                    else
                    begin
                        power_next   = 1'b0;
                        pin_next     = 1'b0;
                        led_run_next = 1'b0;
                    end
                end
                default:
                begin
                    if (phase_next == 2'd0)
                    begin
                        led_run_next = 1'b1;
                        pin_next     = 1'b1;
                    end
                    else
                    begin
                        pin_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // Result built from the next state of the accepted request
    always_comb
    begin
        res_next                 = res_reg;
        valid_next               = valid_reg;
        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next               = 1'b1;
            res_next.pad             = '0;
            res_next.run_seconds     = run_sec_next;
            res_next.speed_level     = off_next - SPEED_BIAS;
            res_next.mode_now        = mode_next;
            res_next.running         = run_next;
            res_next.ccw_led         = led_ccw_next;
            res_next.cw_led          = led_cw_next;
            res_next.stop_led        = led_stop_next;
            res_next.run_led         = led_run_next;
            res_next.direction_relay = dirrel_next;
            res_next.power_relay     = power_next;
            res_next.pwm_out         = pin_next;
        end
    end

    // Hold state and the output register; update state only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            mode_reg     <= MODE_CONT;
            dir_cnt_reg  <= 1'b0;
            off_reg      <= OFF_RESET;
            run_sec_reg  <= RUN_SEC_RESET;
            phase_reg    <= 2'd0;
            slot_reg     <= 8'd0;
            pre_reg      <= '0;
            pwm_cnt_reg  <= 4'd0;
            pin_reg      <= 1'b0;
            power_reg    <= 1'b0;
            dirrel_reg   <= 1'b1;
            led_run_reg  <= 1'b0;
            led_stop_reg <= 1'b0;
            led_cw_reg   <= 1'b0;
            led_ccw_reg  <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                run_reg      <= run_next;
                mode_reg     <= mode_next;
                dir_cnt_reg  <= dir_cnt_next;
                off_reg      <= off_next;
                run_sec_reg  <= run_sec_next;
                phase_reg    <= phase_next;
                slot_reg     <= slot_next;
                pre_reg      <= pre_next;
                pwm_cnt_reg  <= pwm_cnt_next;
                pin_reg      <= pin_next;
                power_reg    <= power_next;
                dirrel_reg   <= dirrel_next;
                led_run_reg  <= led_run_next;
                led_stop_reg <= led_stop_next;
                led_cw_reg   <= led_cw_next;
                led_ccw_reg  <= led_ccw_next;
            end
        end
    end

    // Payload register needs no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg;

endmodule
